FILE: src/scs_pkg.sv
// ----------------------------------------------------------------------------
// Shadow call stack package
// Shared types, opcode constants and instruction decode helpers for the
// shadow call stack tracker.
// ----------------------------------------------------------------------------
package scs_pkg;

  // Result event codes.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PUSH    = 2'd1;
  localparam logic [1:0] EV_POP     = 2'd2;
  localparam logic [1:0] EV_COMPACT = 2'd3;

  // Item kinds.
  localparam logic OP_BLOCK_END = 1'b0;
  localparam logic OP_QUERY     = 1'b1;

  // x86 opcodes of interest.
  localparam logic [7:0] OPC_CALL_FAR  = 8'h9a;
  localparam logic [7:0] OPC_CALL_REL  = 8'he8;
  localparam logic [7:0] OPC_GROUP5    = 8'hff;
  localparam logic [7:0] OPC_RET_IMM   = 8'hc2;
  localparam logic [7:0] OPC_RET       = 8'hc3;
  localparam logic [7:0] OPC_RETF_IMM  = 8'hca;
  localparam logic [7:0] OPC_RETF      = 8'hcb;

  // ModRM reg field values that make group 5 a call.
  localparam logic [2:0] REG_CALL_NEAR = 3'd2;
  localparam logic [2:0] REG_CALL_FAR  = 3'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the accepted item
    logic rd_top;   // read the top frame from the stores
    logic exec;     // apply the push, pop or compaction
    logic load;     // load the result register
  } scs_cmd_t;

  function automatic logic is_call(input logic [7:0] b0, input logic [7:0] b1);
    logic [2:0] reg_field;
    reg_field = b1[5:3];
    return (b0 == OPC_CALL_FAR) || (b0 == OPC_CALL_REL) ||
           ((b0 == OPC_GROUP5) &&
            ((reg_field == REG_CALL_NEAR) || (reg_field == REG_CALL_FAR)));
  endfunction

  function automatic logic is_ret(input logic [7:0] b0);
    return (b0 == OPC_RET_IMM) || (b0 == OPC_RET) ||
           (b0 == OPC_RETF_IMM) || (b0 == OPC_RETF);
  endfunction

endpackage

FILE: src/scs_frame_mem.sv
// ----------------------------------------------------------------------------
// Shadow call stack frame memory
// Three word stores (return word, entry pc, address space) sharing one write
// port and one registered read port.
// ----------------------------------------------------------------------------
module scs_frame_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_ret,
  input  logic [31:0]   wr_entry,
  input  logic [31:0]   wr_space,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_ret,
  output logic [31:0]   rd_entry,
  output logic [31:0]   rd_space
);

  logic [31:0] ret_mem   [DEPTH];
  logic [31:0] entry_mem [DEPTH];
  logic [31:0] space_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ret_mem[wr_addr]   <= wr_ret;
      entry_mem[wr_addr] <= wr_entry;
      space_mem[wr_addr] <= wr_space;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ret   <= ret_mem[rd_addr];
      rd_entry <= entry_mem[rd_addr];
      rd_space <= space_mem[rd_addr];
    end
  end

endmodule

FILE: src/scs_ctrl.sv
// ----------------------------------------------------------------------------
// Shadow call stack controller
// Sequences one item through top read, update, re-read and result load.
// ----------------------------------------------------------------------------
module scs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  logic            out_free,
  output scs_pkg::scs_cmd_t cmd
);
  import scs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD1  = 5'b00010,
    S_EXEC = 5'b00100,
    S_RD2  = 5'b01000,
    S_CMP  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_RD1;
        end
      end
      S_RD1: begin
        cmd.rd_top = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.rd_top = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/scs_datapath.sv
// ----------------------------------------------------------------------------
// Shadow call stack datapath
// Item registers, fill count and bottom pointer of the circular frame buffer,
// the frame memory and the result register.
// ----------------------------------------------------------------------------
module scs_datapath #(
  parameter int STACK_DEPTH = 1024,
  parameter int DISCARD     = 102
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  scs_pkg::scs_cmd_t                    cmd,
  output logic                                 out_free,
  input  logic                                 op,
  input  logic [7:0]                           opcode_byte,
  input  logic [7:0]                           modrm_byte,
  input  logic [31:0]                          next_pc,
  input  logic [31:0]                          stacked_return,
  input  logic [31:0]                          address_space,
  input  logic                                 known_function,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [1:0]                           event_res,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     depth,
  output logic                                 caller_valid,
  output logic [31:0]                          caller_entry
);
  import scs_pkg::*;

  localparam int PTR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int SUM_W = PTR_W + 2;
  localparam int DROP  = (DISCARD < STACK_DEPTH) ? DISCARD : STACK_DEPTH;

  // Captured item.
  logic        item_op;
  logic [7:0]  item_b0;
  logic [7:0]  item_b1;
  logic [31:0] item_npc;
  logic [31:0] item_sret;
  logic [31:0] item_space;
  logic        item_known;

  logic [CNT_W-1:0] fill_count, fill_count_next;
  logic [PTR_W-1:0] bottom_pointer, bottom_pointer_next;
  logic [1:0]       ev_code, ev_code_next;

  logic [CNT_W-1:0] top_off;
  logic [PTR_W-1:0] top_slot;
  logic [PTR_W-1:0] push_slot;
  logic             push_en;
  logic [31:0]      rd_ret, rd_entry, rd_space;
  logic             match;

  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(STACK_DEPTH)) begin
      sum = sum - SUM_W'(STACK_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_op    <= op;
      item_b0    <= opcode_byte;
      item_b1    <= modrm_byte;
      item_npc   <= next_pc;
      item_sret  <= stacked_return;
      item_space <= address_space;
      item_known <= known_function;
    end
  end

  assign top_off   = (fill_count == '0) ? '0 : fill_count - CNT_W'(1);
  assign top_slot  = slot_of(bottom_pointer, top_off);
  assign push_slot = slot_of(bottom_pointer, fill_count);

  // Update decision; the top frame's return word is already in rd_ret.
  always_comb begin
    fill_count_next     = fill_count;
    bottom_pointer_next = bottom_pointer;
    ev_code_next        = EV_NONE;
    push_en             = 1'b0;
    if (item_op == OP_BLOCK_END) begin
      if (is_call(item_b0, item_b1)) begin
        if (fill_count == CNT_W'(STACK_DEPTH)) begin
          bottom_pointer_next = slot_of(bottom_pointer, CNT_W'(DROP));
          fill_count_next     = CNT_W'(STACK_DEPTH - DROP);
          ev_code_next        = EV_COMPACT;
        end else if (item_known) begin
          push_en         = 1'b1;
          fill_count_next = fill_count + CNT_W'(1);
          ev_code_next    = EV_PUSH;
        end
      end else if (is_ret(item_b0)) begin
        if ((fill_count != '0) && (rd_ret == item_npc)) begin
          fill_count_next = fill_count - CNT_W'(1);
          ev_code_next    = EV_POP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      bottom_pointer <= '0;
    end else if (cmd.exec) begin
      fill_count     <= fill_count_next;
      bottom_pointer <= bottom_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ev_code <= ev_code_next;
    end
  end

  scs_frame_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (PTR_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (cmd.exec && push_en),
    .wr_addr  (push_slot),
    .wr_ret   (item_sret),
    .wr_entry (item_npc),
    .wr_space (item_space),
    .rd_en    (cmd.rd_top),
    .rd_addr  (top_slot),
    .rd_ret   (rd_ret),
    .rd_entry (rd_entry),
    .rd_space (rd_space)
  );

  assign match    = (fill_count != '0) && (rd_space == item_space);
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      event_res    <= ev_code;
      depth        <= fill_count;
      caller_valid <= match;
      caller_entry <= match ? rd_entry : 32'd0;
    end
  end

endmodule

FILE: src/shadow_call_stack_tracker.sv
// ----------------------------------------------------------------------------
// Shadow call stack tracker
// Follows calls and returns of traced x86 code on a circular shadow stack
// and reports the calling function of the current address space.
// ----------------------------------------------------------------------------
// Each item occupies the block from the taken beat until its result is
// loaded, in these steps: the beat is taken, the top frame is read from
// the frame memory, the push, pop or compaction is applied, the new top
// frame is read again, and the result register is loaded. Because of the
// memory's registered read port and the controller's one-item-at-a-time
// sequence, a new item is accepted only after the previous one has loaded
// its result. The result register parts the two channels: a new item beat
// is accepted while the previous result still waits under stall, and only
// the final load waits for the register to free up. A call that meets a
// full stack drops the oldest DISCARD frames (at most STACK_DEPTH) by
// moving the bottom pointer and is itself not pushed. The frame stores are
// not cleared after reset; only frames below the fill count are ever used,
// so no clearing pass is needed and the block is ready straight out of
// reset.
// ----------------------------------------------------------------------------
module shadow_call_stack_tracker #(
  parameter int STACK_DEPTH = 1024,
  parameter int DISCARD     = 102
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             op,
  input  logic [7:0]                       opcode_byte,
  input  logic [7:0]                       modrm_byte,
  input  logic [31:0]                      next_pc,
  input  logic [31:0]                      stacked_return,
  input  logic [31:0]                      address_space,
  input  logic                             known_function,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [1:0]                       event_res,
  output logic [$clog2(STACK_DEPTH+1)-1:0] depth,
  output logic                             caller_valid,
  output logic [31:0]                      caller_entry
);
  import scs_pkg::*;

  // Command bundle from the sequencer and the single status it watches.
  scs_cmd_t cmd;
  logic     out_free;

  // The controller owns the sequence; it never looks at payload.
  scs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .out_free   (out_free),
    .cmd        (cmd)
  );

  // The datapath holds the stack state, the frame memory and the result.
  scs_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DISCARD     (DISCARD)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .out_free       (out_free),
    .op             (op),
    .opcode_byte    (opcode_byte),
    .modrm_byte     (modrm_byte),
    .next_pc        (next_pc),
    .stacked_return (stacked_return),
    .address_space  (address_space),
    .known_function (known_function),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .event_res      (event_res),
    .depth          (depth),
    .caller_valid   (caller_valid),
    .caller_entry   (caller_entry)
  );

endmodule
